// File: rtl/dcdr_pkg.sv
// ----------------------------------------------------------------------------
// Disk controller package
// Types, register map, command bits and sector arithmetic shared by the
// disk controller, its checker and its testbench.
// ----------------------------------------------------------------------------
package dcdr_pkg;

  localparam int SectorsPerTrack = 12;
  localparam int WordsPerSector  = 256;
  localparam int MaxCylinder     = 202;

  localparam logic [15:0] RegDriveStatus = 16'o177400;
  localparam logic [15:0] RegError       = 16'o177402;
  localparam logic [15:0] RegCmdStatus   = 16'o177404;
  localparam logic [15:0] RegWordCount   = 16'o177406;
  localparam logic [15:0] RegBusAddr     = 16'o177410;
  localparam logic [15:0] RegDiskAddr    = 16'o177412;
  localparam logic [15:0] RegDataBuffer  = 16'o177416;

  localparam logic [15:0] CsGo   = 16'o000001;
  localparam logic [15:0] CsFunc = 16'o000016;
  localparam logic [15:0] CsRead = 16'o000004;
  localparam logic [15:0] CsIe   = 16'o000100;
  localparam logic [15:0] CsRdy  = 16'o000200;
  localparam logic [15:0] CsDone = 16'o020000;

  localparam logic CfgSectorOneBased = 1'b0;
  localparam logic CfgImagePresent   = 1'b1;

  typedef enum logic [2:0] {
    MODE_READ  = 3'd0,
    MODE_WRITE = 3'd1,
    MODE_POLL  = 3'd2,
    MODE_WORD  = 3'd3,
    MODE_ACK   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_READ_DATA = 2'd0,
    KIND_FETCH     = 2'd1,
    KIND_MEM_WRITE = 2'd2,
    KIND_COMPLETE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] bus_addr;
    logic [7:0]  write_byte;
    logic [15:0] disk_word;
    logic        disk_fail;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  read_data;
    logic [21:0] disk_offset;
    logic [16:0] dma_addr;
    logic [15:0] mem_data;
    logic        irq_pending;
    logic        error_flag;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
  } advance_t;

  // Linear sector number of a disk address word.
  function automatic logic [12:0] lba_of(input logic [15:0] v, input logic from_one);
    logic [3:0] sec;
    logic [8:0] track;
    sec   = v[3:0];
    track = {v[12:5], v[4]};
    if (from_one) begin
      if (sec == 4'd0) begin
        sec = 4'(SectorsPerTrack - 1);
      end else begin
        sec = sec - 4'd1;
      end
    end
    return 13'(track * SectorsPerTrack) + 13'(sec);
  endfunction

  // Step a disk address to the next sector; ok clears past the last cylinder.
  function automatic advance_t advance_sector(input logic [15:0] v);
    logic [4:0] sec;
    logic       surf;
    logic [8:0] cyl;
    advance_t   res;
    sec    = {1'b0, v[3:0]} + 5'd1;
    surf   = v[4];
    cyl    = {1'b0, v[12:5]};
    res.ok = 1'b1;
    if (sec >= 5'(SectorsPerTrack)) begin
      sec = 5'd0;
      if (surf) begin
        surf = 1'b0;
        cyl  = cyl + 9'd1;
        if (cyl > 9'(MaxCylinder)) begin
          res.ok = 1'b0;
        end
      end else begin
        surf = 1'b1;
      end
    end
    res.value = {v[15:13], cyl[7:0], surf, sec[3:0]};
    return res;
  endfunction

  function automatic logic [15:0] merge_byte(input logic [15:0] old, input logic hi,
                                             input logic [7:0] b);
    return hi ? {b, old[7:0]} : {old[15:8], b};
  endfunction

endpackage

// File: rtl/dcdr_if.sv
// ----------------------------------------------------------------------------
// Disk controller channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface dcdr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] bus_addr;
  logic [7:0]  write_byte;
  logic [15:0] disk_word;
  logic        disk_fail;

  modport source (output valid, mode, bus_addr, write_byte, disk_word, disk_fail,
                  input ready);
  modport sink (input valid, mode, bus_addr, write_byte, disk_word, disk_fail,
                output ready);
endinterface

interface dcdr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  read_data;
  logic [21:0] disk_offset;
  logic [16:0] dma_addr;
  logic [15:0] mem_data;
  logic        irq_pending;
  logic        error_flag;
  logic        last;

  modport source (output valid, kind, read_data, disk_offset, dma_addr, mem_data,
                  irq_pending, error_flag, last, input ready);
  modport sink (input valid, kind, read_data, disk_offset, dma_addr, mem_data,
                irq_pending, error_flag, last, output ready);
endinterface

interface dcdr_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [0:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/disk_controller_dma_regs.sv
// ----------------------------------------------------------------------------
// Disk controller with DMA read registers
// Seven byte-addressable registers, a poll-started READ transfer that turns
// fetched disk words into memory writes, and command completion reporting.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries bus reads and writes, polls, arriving disk words
// and interrupt acknowledges. Each accepted beat is held in an input
// register and acted on from there, which pushes zero, one or
// two result beats into a four-entry result queue that drives rsp.
// The first result of an item passes through the input register and then
// the result queue before it is presented on rsp.
// Items that give at most one result are taken once per cycle while rsp
// takes every result; an arriving disk word gives a memory write and then a
// fetch request or a completion, so a stream of disk words is paced by the
// single result port draining the queue.
// The input register is released while results wait, and items are acted
// on as long as the queue has room for two more results; when rsp stalls,
// the queue fills and req.ready drops.
// The cfg channel is always ready: index 0 selects one-based sector numbers,
// index 1 marks the disk image as attached.
// Reset (rst, synchronous) empties both stages, clears all registers and
// sets RDY in the command register.
// ----------------------------------------------------------------------------
module disk_controller_dma_regs
  import dcdr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dcdr_req_if.sink   req,
  dcdr_rsp_if.source rsp,
  dcdr_cfg_if.sink   cfg
);

  logic        sector_from_one;
  logic        image_present;
  logic [15:0] drive_status, drive_status_next;
  logic [15:0] error_reg, error_reg_next;
  logic [15:0] command_status, command_status_next;
  logic [15:0] word_count, word_count_next;
  logic [15:0] bus_address, bus_address_next;
  logic [15:0] disk_address, disk_address_next;
  logic [15:0] data_buffer, data_buffer_next;
  logic        irq_flag, irq_flag_next;
  logic        irq_enabled, irq_enabled_next;
  logic        busy, busy_next;
  logic [15:0] words_left, words_left_next;
  logic [7:0]  sector_word, sector_word_next;
  logic [16:0] transfer_addr, transfer_addr_next;
  logic [15:0] current_disk_addr, current_disk_addr_next;
  logic [15:0] current_count, current_count_next;

  req_t        item;
  logic        item_valid;
  logic        process;

  rsp_t        queue [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        pop;

  rsp_t        res0, res1;
  logic [1:0]  num_res;

  logic [15:0] reg_addr;
  logic [15:0] reg_value;
  logic        is_read_cmd;
  logic [8:0]  wis_inc;
  logic        sector_wrap;
  advance_t    adv;
  logic [15:0] cda;
  logic        xfer_done;

  assign process   = item_valid && (count <= 3'd2);
  assign req.ready = !item_valid || process;
  assign cfg.ready = 1'b1;
  assign pop       = rsp.valid && rsp.ready;

  assign rsp.valid       = (count != 3'd0);
  assign rsp.kind        = queue[rd_ptr].kind;
  assign rsp.read_data   = queue[rd_ptr].read_data;
  assign rsp.disk_offset = queue[rd_ptr].disk_offset;
  assign rsp.dma_addr    = queue[rd_ptr].dma_addr;
  assign rsp.mem_data    = queue[rd_ptr].mem_data;
  assign rsp.irq_pending = queue[rd_ptr].irq_pending;
  assign rsp.error_flag  = queue[rd_ptr].error_flag;
  assign rsp.last        = queue[rd_ptr].last;

  assign reg_addr = {item.bus_addr[15:1], 1'b0};

  always_comb begin
    reg_value = '0;
    unique case (reg_addr)
      RegDriveStatus: reg_value = drive_status;
      RegError:       reg_value = error_reg;
      RegCmdStatus:   reg_value = command_status;
      RegWordCount:   reg_value = word_count;
      RegBusAddr:     reg_value = bus_address;
      RegDiskAddr:    reg_value = disk_address;
      RegDataBuffer:  reg_value = data_buffer;
      default:        reg_value = '0;
    endcase
  end

  assign is_read_cmd = ((command_status & CsFunc) == CsRead) && word_count[15];
  assign wis_inc     = {1'b0, sector_word} + 9'd1;
  assign sector_wrap = (wis_inc >= 9'(WordsPerSector));
  assign adv         = advance_sector(current_disk_addr);

  always_comb begin
    drive_status_next      = drive_status;
    error_reg_next         = error_reg;
    command_status_next    = command_status;
    word_count_next        = word_count;
    bus_address_next       = bus_address;
    disk_address_next      = disk_address;
    data_buffer_next       = data_buffer;
    irq_flag_next          = irq_flag;
    irq_enabled_next       = irq_enabled;
    busy_next              = busy;
    words_left_next        = words_left;
    sector_word_next       = sector_word;
    transfer_addr_next     = transfer_addr;
    current_disk_addr_next = current_disk_addr;
    current_count_next     = current_count;
    res0                   = '0;
    res1                   = '0;
    num_res                = 2'd0;
    cda                    = current_disk_addr;
    xfer_done              = 1'b0;

    unique case (item.mode)
      MODE_READ: begin
        res0.kind      = KIND_READ_DATA;
        res0.read_data = item.bus_addr[0] ? reg_value[15:8] : reg_value[7:0];
        res0.last      = 1'b1;
        num_res        = 2'd1;
      end
      MODE_WRITE: begin
        unique case (reg_addr)
          RegDriveStatus: drive_status_next =
              merge_byte(drive_status, item.bus_addr[0], item.write_byte);
          RegError: error_reg_next =
              merge_byte(error_reg, item.bus_addr[0], item.write_byte);
          RegCmdStatus: begin
            command_status_next =
                merge_byte(command_status, item.bus_addr[0], item.write_byte);
            if (!item.bus_addr[0] && item.write_byte[0]) begin
              command_status_next = command_status_next & ~(CsRdy | CsDone);
              irq_enabled_next    = item.write_byte[6];
            end
          end
          RegWordCount: word_count_next =
              merge_byte(word_count, item.bus_addr[0], item.write_byte);
          RegBusAddr: bus_address_next =
              merge_byte(bus_address, item.bus_addr[0], item.write_byte);
          RegDiskAddr: disk_address_next =
              merge_byte(disk_address, item.bus_addr[0], item.write_byte);
          RegDataBuffer: data_buffer_next =
              merge_byte(data_buffer, item.bus_addr[0], item.write_byte);
          default: ;
        endcase
      end
      MODE_POLL: begin
        if (!busy && command_status[0]) begin
          num_res   = 2'd1;
          res0.last = 1'b1;
          if (is_read_cmd && image_present) begin
            words_left_next        = 16'd0 - word_count;
            transfer_addr_next     = {1'b0, bus_address};
            current_disk_addr_next = disk_address;
            current_count_next     = word_count;
            sector_word_next       = 8'd0;
            busy_next              = 1'b1;
            res0.kind              = KIND_FETCH;
            res0.disk_offset       = {lba_of(disk_address, sector_from_one), 9'd0};
          end else begin
            if (is_read_cmd) begin
              error_reg_next = 16'd1;
            end
            command_status_next = CsRdy | CsDone | (irq_enabled ? CsIe : 16'd0);
            if (irq_enabled) begin
              irq_flag_next = 1'b1;
            end
            busy_next = 1'b0;
            res0.kind = KIND_COMPLETE;
          end
        end
      end
      MODE_WORD: begin
        if (busy) begin
          if (item.disk_fail) begin
            error_reg_next      = 16'd1;
            disk_address_next   = current_disk_addr;
            word_count_next     = current_count;
            command_status_next = CsRdy | CsDone | (irq_enabled ? CsIe : 16'd0);
            if (irq_enabled) begin
              irq_flag_next = 1'b1;
            end
            busy_next = 1'b0;
            res0.kind = KIND_COMPLETE;
            res0.last = 1'b1;
            num_res   = 2'd1;
          end else begin
            res0.kind           = KIND_MEM_WRITE;
            res0.dma_addr       = transfer_addr;
            res0.mem_data       = item.disk_word;
            num_res             = 2'd2;
            transfer_addr_next  = transfer_addr + 17'd2;
            bus_address_next    = bus_address + 16'd2;
            current_count_next  = current_count + 16'd1;
            words_left_next     = words_left - 16'd1;
            sector_word_next    = sector_wrap ? 8'd0 : wis_inc[7:0];
            if (sector_wrap) begin
              if (adv.ok) begin
                cda = adv.value;
              end else begin
                error_reg_next = 16'd1;
                xfer_done      = 1'b1;
              end
            end
            current_disk_addr_next = cda;
            if (words_left_next == 16'd0) begin
              xfer_done = 1'b1;
            end
            res1.last = 1'b1;
            if (xfer_done) begin
              disk_address_next   = cda;
              word_count_next     = current_count_next;
              command_status_next = CsRdy | CsDone | (irq_enabled ? CsIe : 16'd0);
              if (irq_enabled) begin
                irq_flag_next = 1'b1;
              end
              busy_next = 1'b0;
              res1.kind = KIND_COMPLETE;
            end else begin
              res1.kind        = KIND_FETCH;
              res1.disk_offset = {lba_of(cda, sector_from_one), sector_word_next, 1'b0};
            end
          end
        end
      end
      MODE_ACK: irq_flag_next = 1'b0;
      default: ;
    endcase

    res0.irq_pending = irq_flag_next;
    res0.error_flag  = (error_reg_next != 16'd0);
    res1.irq_pending = irq_flag_next;
    res1.error_flag  = (error_reg_next != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.mode       <= req.mode;
      item.bus_addr   <= req.bus_addr;
      item.write_byte <= req.write_byte;
      item.disk_word  <= req.disk_word;
      item.disk_fail  <= req.disk_fail;
    end
    if (process && (num_res != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (process && (num_res == 2'd2)) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid        <= 1'b0;
      wr_ptr            <= '0;
      rd_ptr            <= '0;
      count             <= '0;
      sector_from_one   <= 1'b0;
      image_present     <= 1'b0;
      drive_status      <= '0;
      error_reg         <= '0;
      command_status    <= CsRdy;
      word_count        <= '0;
      bus_address       <= '0;
      disk_address      <= '0;
      data_buffer       <= '0;
      irq_flag          <= 1'b0;
      irq_enabled       <= 1'b0;
      busy              <= 1'b0;
      words_left        <= '0;
      sector_word       <= '0;
      transfer_addr     <= '0;
      current_disk_addr <= '0;
      current_count     <= '0;
    end else begin
      if (req.ready) begin
        item_valid <= req.valid;
      end
      wr_ptr <= process ? (wr_ptr + num_res) : wr_ptr;
      rd_ptr <= pop ? (rd_ptr + 2'd1) : rd_ptr;
      count  <= count + (process ? {1'b0, num_res} : 3'd0) - {2'b00, pop};
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CfgSectorOneBased) begin
          sector_from_one <= cfg.data[0];
        end else begin
          image_present <= cfg.data[0];
        end
      end
      if (process) begin
        drive_status      <= drive_status_next;
        error_reg         <= error_reg_next;
        command_status    <= command_status_next;
        word_count        <= word_count_next;
        bus_address       <= bus_address_next;
        disk_address      <= disk_address_next;
        data_buffer       <= data_buffer_next;
        irq_flag          <= irq_flag_next;
        irq_enabled       <= irq_enabled_next;
        busy              <= busy_next;
        words_left        <= words_left_next;
        sector_word       <= sector_word_next;
        transfer_addr     <= transfer_addr_next;
        current_disk_addr <= current_disk_addr_next;
        current_count     <= current_count_next;
      end
    end
  end

endmodule

// File: rtl/dcdr_checker.sv
// ----------------------------------------------------------------------------
// Disk controller port checker
// Checks result ordering and handshake behavior seen at the controller ports.
// ----------------------------------------------------------------------------
module dcdr_checker
  import dcdr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_kind,
  input logic       rsp_last
);

  logic rsp_beat;
  assign rsp_beat = rsp_valid && rsp_ready;

  // A reset leaves no result beat pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // A memory write is always followed by a second beat of the same item.
  a_write_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == KIND_MEM_WRITE) |-> !rsp_last)
    else $error("memory write marked as last beat");

  a_write_follow: assert property (@(posedge clk) disable iff (rst)
    rsp_beat && (rsp_kind == KIND_MEM_WRITE) |=> rsp_valid &&
    (rsp_kind == KIND_FETCH || rsp_kind == KIND_COMPLETE))
    else $error("memory write not followed by fetch or completion");

  // A register read is a single-beat item.
  a_read_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == KIND_READ_DATA) |-> rsp_last)
    else $error("read data beat not last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
    else $error("stalled result beat changed");

endmodule

bind disk_controller_dma_regs dcdr_checker u_dcdr_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_kind  (rsp.kind),
  .rsp_last  (rsp.last)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Disk controller DMA register block testbench
// Drives bus reads and writes, polls, disk words and interrupt acknowledges
// through bursty handshakes. A shadow of the controller registers predicts
// every result beat, and each received beat is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dcdr_pkg::*;

  localparam int CycleLimit = 1_000_000;

  class disk_ctrl_shadow;
    bit count_from_one;
    bit image_on;
    logic [15:0] drive_status, error_reg, cmd_status, word_count;
    logic [15:0] bus_address, disk_address, data_buffer;
    bit irq_flag, irq_enabled, busy;
    logic [15:0] words_left, cur_disk_addr, cur_count;
    logic [7:0] sector_word;
    logic [16:0] xfer_addr;
    rsp_t awaited_results[$];
    int errors;

    function new();
      count_from_one = 0;
      image_on = 0;
      drive_status = '0;
      error_reg = '0;
      cmd_status = CsRdy;
      word_count = '0;
      bus_address = '0;
      disk_address = '0;
      data_buffer = '0;
      irq_flag = 0;
      irq_enabled = 0;
      busy = 0;
      words_left = '0;
      cur_disk_addr = '0;
      cur_count = '0;
      sector_word = '0;
      xfer_addr = '0;
      errors = 0;
    endfunction

    function void set_config(logic idx, logic val);
      if (idx == CfgSectorOneBased) begin
        count_from_one = val;
      end else begin
        image_on = val;
      end
    endfunction

    function logic [15:0] with_byte(logic [15:0] old, logic hi, logic [7:0] b);
      return hi ? {b, old[7:0]} : {old[15:8], b};
    endfunction

    function bit is_reg(logic [15:0] a);
      case ({a[15:1], 1'b0})
        RegDriveStatus, RegError, RegCmdStatus, RegWordCount,
        RegBusAddr, RegDiskAddr, RegDataBuffer: return 1;
        default: return 0;
      endcase
    endfunction

    function logic [15:0] reg_value(logic [15:0] a);
      case ({a[15:1], 1'b0})
        RegDriveStatus: return drive_status;
        RegError:       return error_reg;
        RegCmdStatus:   return cmd_status;
        RegWordCount:   return word_count;
        RegBusAddr:     return bus_address;
        RegDiskAddr:    return disk_address;
        RegDataBuffer:  return data_buffer;
        default:        return 16'h0000;
      endcase
    endfunction

    function void store_byte(logic [15:0] a, logic [7:0] b);
      case ({a[15:1], 1'b0})
        RegDriveStatus: drive_status = with_byte(drive_status, a[0], b);
        RegError:       error_reg = with_byte(error_reg, a[0], b);
        RegCmdStatus:   cmd_status = with_byte(cmd_status, a[0], b);
        RegWordCount:   word_count = with_byte(word_count, a[0], b);
        RegBusAddr:     bus_address = with_byte(bus_address, a[0], b);
        RegDiskAddr:    disk_address = with_byte(disk_address, a[0], b);
        RegDataBuffer:  data_buffer = with_byte(data_buffer, a[0], b);
        default: ;
      endcase
    endfunction

    function int unsigned linear_sector(logic [15:0] v);
      int unsigned sec;
      sec = int'(v[3:0]);
      if (count_from_one) begin
        if (sec == 0) sec = SectorsPerTrack;
        sec = sec - 1;
      end
      return (int'(v[12:5]) * 2 + int'(v[4])) * SectorsPerTrack + sec;
    endfunction

    function logic [21:0] fetch_offset();
      return 22'(linear_sector(cur_disk_addr) * 512 + int'(sector_word) * 2);
    endfunction

    function bit next_sector(inout logic [15:0] v);
      int sec, surf, cyl;
      sec = int'(v[3:0]) + 1;
      surf = int'(v[4]);
      cyl = int'(v[12:5]);
      if (sec >= SectorsPerTrack) begin
        sec = 0;
        surf++;
        if (surf >= 2) begin
          surf = 0;
          cyl++;
          if (cyl > MaxCylinder) return 0;
        end
      end
      v = {v[15:13], 8'(cyl), 1'(surf), 4'(sec)};
      return 1;
    endfunction

    function void finish_command();
      cmd_status = CsRdy | CsDone | (irq_enabled ? CsIe : 16'h0000);
      if (irq_enabled) irq_flag = 1;
      busy = 0;
    endfunction

    function void push(kind_t k, logic [7:0] rd, logic [21:0] off, logic [16:0] ma,
                       logic [15:0] md, bit last);
      rsp_t r;
      r.kind = k;
      r.read_data = rd;
      r.disk_offset = off;
      r.dma_addr = ma;
      r.mem_data = md;
      r.irq_pending = irq_flag;
      r.error_flag = (error_reg != 16'h0000);
      r.last = last;
      awaited_results.push_back(r);
    endfunction

    // Returns 1 when the beat had any effect on the controller.
    function bit note_request(req_t r);
      logic [15:0] v;
      logic [16:0] wr_addr;
      bit finished;
      case (r.mode)
        MODE_READ: begin
          v = reg_value(r.bus_addr);
          push(KIND_READ_DATA, r.bus_addr[0] ? v[15:8] : v[7:0], '0, '0, '0, 1);
          return 1;
        end
        MODE_WRITE: begin
          if (!is_reg(r.bus_addr)) return 0;
          store_byte(r.bus_addr, r.write_byte);
          if ({r.bus_addr[15:1], 1'b0} == RegCmdStatus && !r.bus_addr[0] &&
              (cmd_status & CsGo) != 0) begin
            cmd_status = cmd_status & ~(CsRdy | CsDone);
            irq_enabled = (cmd_status & CsIe) != 0;
          end
          return 1;
        end
        MODE_POLL: begin
          if (busy || (cmd_status & CsGo) == 0) return 0;
          if ((cmd_status & CsFunc) == CsRead && word_count[15]) begin
            if (!image_on) begin
              error_reg = 16'd1;
            end else begin
              words_left = 16'h0000 - word_count;
              xfer_addr = {1'b0, bus_address};
              cur_disk_addr = disk_address;
              cur_count = word_count;
              sector_word = '0;
              busy = 1;
              push(KIND_FETCH, '0, fetch_offset(), '0, '0, 1);
              return 1;
            end
          end
          finish_command();
          push(KIND_COMPLETE, '0, '0, '0, '0, 1);
          return 1;
        end
        MODE_WORD: begin
          if (!busy) return 0;
          if (r.disk_fail) begin
            error_reg = 16'd1;
            disk_address = cur_disk_addr;
            word_count = cur_count;
            finish_command();
            push(KIND_COMPLETE, '0, '0, '0, '0, 1);
            return 1;
          end
          wr_addr = xfer_addr;
          xfer_addr = xfer_addr + 17'd2;
          bus_address = bus_address + 16'd2;
          cur_count = cur_count + 16'd1;
          words_left = words_left - 16'd1;
          sector_word = sector_word + 8'd1;
          finished = 0;
          if (int'(sector_word) >= WordsPerSector || sector_word == 0) begin
            sector_word = '0;
            if (!next_sector(cur_disk_addr)) begin
              error_reg = 16'd1;
              finished = 1;
            end
          end
          if (words_left == 0) finished = 1;
          if (finished) begin
            disk_address = cur_disk_addr;
            word_count = cur_count;
            finish_command();
          end
          push(KIND_MEM_WRITE, '0, '0, wr_addr, r.disk_word, 0);
          if (finished) begin
            push(KIND_COMPLETE, '0, '0, '0, '0, 1);
          end else begin
            push(KIND_FETCH, '0, fetch_offset(), '0, '0, 1);
          end
          return 1;
        end
        MODE_ACK: begin
          irq_flag = 0;
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, actual kind %0d", $time, got.kind);
        return;
      end
      want = awaited_results.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
      compare_field("disk_offset", 32'(want.disk_offset), 32'(got.disk_offset));
      compare_field("dma_addr", 32'(want.dma_addr), 32'(got.dma_addr));
      compare_field("mem_data", 32'(want.mem_data), 32'(got.mem_data));
      compare_field("irq_pending", 32'(want.irq_pending), 32'(got.irq_pending));
      compare_field("error_flag", 32'(want.error_flag), 32'(got.error_flag));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int cycles = 0;
  int burst_left = 0;
  int active_items = 0;
  disk_ctrl_shadow board = new();

  dcdr_req_if req();
  dcdr_rsp_if rsp();
  dcdr_cfg_if cfg();

  disk_controller_dma_regs dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[disk_controller_dma_regs] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      board.check_result({rsp.kind, rsp.read_data, rsp.disk_offset, rsp.dma_addr,
                          rsp.mem_data, rsp.irq_pending, rsp.error_flag, rsp.last});
    end
  end

  initial begin
    int rx_cycles;
    int hold;
    int style;
    int style_left;
    rx_cycles = 0;
    hold = 0;
    style = 0;
    style_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles % 2500 == 1200) hold = 400;
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 3);
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        case (style)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= 1'($urandom_range(0, 1));
          2: rsp.ready <= ($urandom_range(0, 9) != 0);
          default: rsp.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  function automatic req_t make_req(logic [2:0] m, logic [15:0] a, logic [7:0] b,
                                    logic [15:0] w, logic f);
    req_t r;
    r.mode = m;
    r.bus_addr = a;
    r.write_byte = b;
    r.disk_word = w;
    r.disk_fail = f;
    return r;
  endfunction

  function automatic logic [15:0] pick_addr();
    if ($urandom_range(0, 3) != 0) return {12'hFF0, 4'($urandom_range(0, 15))};
    return 16'($urandom);
  endfunction

  task automatic send_item(input req_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req.valid <= 1'b1;
    req.mode <= item.mode;
    req.bus_addr <= item.bus_addr;
    req.write_byte <= item.write_byte;
    req.disk_word <= item.disk_word;
    req.disk_fail <= item.disk_fail;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (board.note_request(item)) active_items++;
    @(negedge clk);
  endtask

  task automatic write_setting(logic idx, logic val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    board.set_config(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_settings(logic from_one, logic image_on);
    write_setting(CfgSectorOneBased, from_one);
    write_setting(CfgImagePresent, image_on);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (board.awaited_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg_word(logic [15:0] base, logic [15:0] value);
    if ($urandom_range(0, 1) != 0) begin
      send_item(make_req(MODE_WRITE, base, value[7:0], 16'($urandom), 1'b0));
      send_item(make_req(MODE_WRITE, base | 16'h1, value[15:8], 16'($urandom), 1'b0));
    end else begin
      send_item(make_req(MODE_WRITE, base | 16'h1, value[15:8], 16'($urandom), 1'b0));
      send_item(make_req(MODE_WRITE, base, value[7:0], 16'($urandom), 1'b0));
    end
  endtask

  task automatic abort_transfer();
    if (board.busy) begin
      send_item(make_req(MODE_WORD, 16'($urandom), 8'($urandom), 16'($urandom), 1'b1));
    end
  endtask

  task automatic directed_checks();
    send_item(make_req(MODE_READ, RegCmdStatus, 8'h00, 16'h0000, 1'b0));
    send_item(make_req(MODE_READ, RegCmdStatus | 16'h1, 8'hFF, 16'hFFFF, 1'b1));
    send_item(make_req(MODE_READ, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_item(make_req(MODE_READ, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0));
    send_item(make_req(MODE_WRITE, RegWordCount, 8'hFE, 16'h0000, 1'b0));
    send_item(make_req(MODE_WRITE, RegWordCount | 16'h1, 8'hFF, 16'h0000, 1'b0));
    send_item(make_req(MODE_WRITE, RegBusAddr, 8'hFE, 16'h0000, 1'b0));
    send_item(make_req(MODE_WRITE, RegBusAddr | 16'h1, 8'hFF, 16'h0000, 1'b0));
    send_item(make_req(MODE_WRITE, RegDiskAddr, 8'h5B, 16'h0000, 1'b0));
    send_item(make_req(MODE_WRITE, RegDiskAddr | 16'h1, 8'hF9, 16'h0000, 1'b0));
    send_item(make_req(MODE_WRITE, RegCmdStatus, 8'(CsGo | CsRead | CsIe), 16'h0, 1'b0));
    send_item(make_req(MODE_POLL, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_item(make_req(MODE_WORD, 16'h0000, 8'h00, 16'hFFFF, 1'b0));
    send_item(make_req(MODE_WORD, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_item(make_req(MODE_POLL, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_item(make_req(MODE_WORD, 16'h0000, 8'h00, 16'h1234, 1'b0));
    send_item(make_req(MODE_ACK, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_item(make_req(3'd5, RegCmdStatus, 8'hFF, 16'hFFFF, 1'b1));
    send_item(make_req(3'd6, RegWordCount, 8'hFF, 16'hFFFF, 1'b1));
    send_item(make_req(3'd7, RegError, 8'hFF, 16'hFFFF, 1'b1));
    send_item(make_req(MODE_WRITE, RegCmdStatus, 8'(CsGo), 16'h0000, 1'b0));
    send_item(make_req(MODE_POLL, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_item(make_req(MODE_WRITE, RegWordCount | 16'h1, 8'hFF, 16'h0000, 1'b0));
    send_item(make_req(MODE_WRITE, RegCmdStatus, 8'(CsGo | CsRead | CsIe), 16'h0, 1'b0));
    send_item(make_req(MODE_POLL, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_item(make_req(MODE_WORD, 16'h0000, 8'h00, 16'hA5A5, 1'b1));
    send_item(make_req(MODE_READ, RegError, 8'h00, 16'h0000, 1'b0));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) begin
      send_item(make_req(3'($urandom_range(0, 7)), pick_addr(), 8'($urandom),
                         16'($urandom), 1'($urandom)));
    end
  endtask

  task automatic transfer_sequence();
    bit long_run;
    bit fail;
    int n;
    int sent;
    logic [15:0] wc;
    logic [15:0] da;
    logic [7:0] cmd_lo;
    abort_transfer();
    if ($urandom_range(0, 5) == 0) begin
      send_item(make_req(MODE_ACK, pick_addr(), 8'($urandom), 16'($urandom), 1'($urandom)));
    end
    long_run = ($urandom_range(0, 23) == 0);
    n = long_run ? $urandom_range(250, 300) : $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0: wc = 16'h0000;
      1: wc = 16'($urandom_range(1, 32767));
      default: wc = 16'h0000 - 16'(n);
    endcase
    write_reg_word(RegWordCount, wc);
    write_reg_word(RegBusAddr, ($urandom_range(0, 7) == 0)
                               ? (16'hFFF0 | 16'($urandom_range(0, 15))) : 16'($urandom));
    if (long_run) begin
      da = {3'($urandom),
            8'(($urandom_range(0, 2) == 0) ? $urandom_range(190, 201) : MaxCylinder),
            1'b1, 4'($urandom_range(10, 15))};
    end else begin
      da = 16'($urandom);
    end
    write_reg_word(RegDiskAddr, da);
    if ($urandom_range(0, 3) == 0) begin
      send_item(make_req(MODE_WRITE, RegCmdStatus | 16'h1, 8'($urandom), 16'($urandom),
                         1'b0));
    end
    cmd_lo = {1'($urandom), 1'($urandom), 2'($urandom),
              ($urandom_range(0, 4) == 0) ? 3'($urandom) : CsRead[3:1],
              1'($urandom_range(0, 9) != 0)};
    send_item(make_req(MODE_WRITE, RegCmdStatus, cmd_lo, 16'($urandom), 1'b0));
    if ($urandom_range(0, 3) == 0) begin
      send_item(make_req(MODE_READ, pick_addr(), 8'($urandom), 16'($urandom), 1'b0));
    end
    send_item(make_req(MODE_POLL, pick_addr(), 8'($urandom), 16'($urandom), 1'($urandom)));
    sent = 0;
    while (board.busy) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(make_req(3'($urandom_range(0, 2)), pick_addr(), 8'($urandom),
                           16'($urandom), 1'($urandom)));
      end
      fail = (sent >= 600) || (!long_run && $urandom_range(0, 39) == 0);
      send_item(make_req(MODE_WORD, 16'($urandom), 8'($urandom), 16'($urandom), fail));
      sent++;
    end
    repeat ($urandom_range(0, 2)) begin
      send_item(make_req(MODE_READ, pick_addr(), 8'($urandom), 16'($urandom), 1'b0));
    end
  endtask

  task automatic run_random(int target);
    int start;
    start = active_items;
    while (active_items - start < target) begin
      if ($urandom_range(0, 4) == 0) begin
        noise_burst();
      end else begin
        transfer_sequence();
      end
    end
    abort_transfer();
    drain();
  endtask

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_READ;
    req.bus_addr = '0;
    req.write_byte = '0;
    req.disk_word = '0;
    req.disk_fail = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = 1'b0;
    cfg.data = 1'b0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    apply_settings(1'b0, 1'b1);
    directed_checks();
    run_random(400);
    apply_settings(1'b1, 1'b1);
    run_random(400);
    apply_settings(1'b1, 1'b0);
    run_random(300);
    apply_settings(1'b0, 1'b0);
    run_random(300);
    apply_settings(1'b1, 1'b1);
    run_random(400);
    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.awaited_results.size() == 0) begin
      $display("[disk_controller_dma_regs] OK");
    end else begin
      $display("[disk_controller_dma_regs] ERROR");
    end
    $finish;
  end

endmodule

// File: disk_controller_dma_regs.f
rtl/dcdr_pkg.sv
rtl/dcdr_if.sv
rtl/disk_controller_dma_regs.sv
rtl/dcdr_checker.sv
tb/tb.sv
